// ----- rtl/scanline_sprite_selector_top_defines.svh -----
// Assertion macros for the scanline sprite selector.
// Included by scanline_sprite_selector_top; expects clk_i and rst_ni in scope.
`ifndef SCANLINE_SPRITE_SELECTOR_TOP_DEFINES_SVH
`define SCANLINE_SPRITE_SELECTOR_TOP_DEFINES_SVH

// Check sampled on the rising clock edge, switched off while reset is held.
`define SSEL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check sampled on the rising clock edge, live during reset as well.
`define SSEL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/ssel_pkg.sv -----
// Shared types, constants and the sort-order function of the scanline sprite selector.
// No dependencies; used by ssel_cell and scanline_sprite_selector_top.
package ssel_pkg;

  localparam int unsigned LIST_DEPTH   = 10;
  localparam int unsigned ENTRY_COUNT  = 40;
  localparam int unsigned LINE_W       = 8;
  localparam int unsigned IDX_W        = 6;
  localparam int unsigned POS_W        = 8;
  localparam int unsigned Y_OFFSET     = 16;
  localparam int unsigned SHORT_HEIGHT = 8;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] x;
  } pick_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  // True when a sorts strictly before b: by X, then by entry number.
  function automatic logic sorts_before(pick_t a, pick_t b);
    logic res;
    if (a.x != b.x) begin
      res = (a.x < b.x);
    end else begin
      res = (a.idx < b.idx);
    end
    return res;
  endfunction

endpackage

// ----- rtl/ssel_cell.sv -----
// One slot of the sorted object list: holds a pick and its valid bit.
// Depends on ssel_pkg for pick_t, cell_ctrl_t and sorts_before.
module ssel_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssel_pkg::cell_ctrl_t ctrl_i,
  input  ssel_pkg::pick_t    new_i,
  input  logic               left_vld_i,
  input  ssel_pkg::pick_t    left_pick_i,
  input  logic               left_keep_i,
  output logic               vld_o,
  output ssel_pkg::pick_t    pick_o,
  output logic               keep_o
);

  logic            vld_q, vld_d;
  ssel_pkg::pick_t pick_q, pick_d;

  // The held pick stays put when it sorts strictly before the new one.
  assign keep_o = vld_q & ssel_pkg::sorts_before(pick_q, new_i);

  always_comb begin
    vld_d  = vld_q;
    pick_d = pick_q;
    if (ctrl_i.insert && !keep_o) begin
      if (left_keep_i) begin
        // new pick lands here
        vld_d  = 1'b1;
        pick_d = new_i;
      end else begin
        // make room: take the neighbour's pick, the last one falls off the end
        vld_d  = left_vld_i;
        pick_d = left_pick_i;
      end
    end else if (ctrl_i.shift) begin
      vld_d  = left_vld_i;
      pick_d = left_pick_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q <= pick_d;
  end

  assign vld_o  = vld_q;
  assign pick_o = pick_q;

endmodule

// ----- rtl/scanline_sprite_selector_top.sv -----
// Scanline sprite selector: a row of LIST_DEPTH cells keeps the chosen objects sorted.
// Each entry beat is accepted in S_IDLE, then inserted in S_INSERT while tready is low.
// On a final entry the row shifts towards the top slot one cell a cycle, stalling while a
// pick in the top slot waits on the output; one result leaves a cycle while taken.
// An empty list gives a single result, flagged none_chosen, after the final beat.
// Reset is asynchronous, active low: empties the list, clears tall_objects and the output.
`include "scanline_sprite_selector_top_defines.svh"

module scanline_sprite_selector_top #(
  parameter int unsigned LIST_DEPTH  = ssel_pkg::LIST_DEPTH,
  parameter int unsigned ENTRY_COUNT = ssel_pkg::ENTRY_COUNT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // entry stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] scan_line, [13:8] entry_index, [21:14] entry_y, [29:22] entry_x, [31:30] zero
  input  logic [31:0] s_axis_tdata_i,
  input  logic        s_axis_tlast_i,   // final_entry
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [5:0] chosen_index, [13:6] chosen_x, [15:14] zero
  output logic [15:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o,   // none_chosen
  output logic        m_axis_tlast_o    // last_of_run
);

  localparam int unsigned LW = ssel_pkg::LINE_W;
  localparam int unsigned IW = ssel_pkg::IDX_W;
  localparam int unsigned PW = ssel_pkg::POS_W;
  localparam logic [LIST_DEPTH-1:0] TopOnly = LIST_DEPTH'(1) << (LIST_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_INSERT = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_EMPTY  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration register
  logic tall_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr == 2'd0) ? {31'd0, tall_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tall_q <= 1'b0;
    end else if (cfg_wr) begin
      tall_q <= pwdata[0];
    end
  end

  // accepted entry
  logic [LW-1:0]   line_q;
  logic [PW-1:0]   y_q;
  ssel_pkg::pick_t item_q;
  logic            fin_q;
  logic            in_acc;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      line_q     <= s_axis_tdata_i[7:0];
      item_q.idx <= s_axis_tdata_i[13:8];
      y_q        <= s_axis_tdata_i[21:14];
      item_q.x   <= s_axis_tdata_i[29:22];
      fin_q      <= s_axis_tlast_i;
    end
  end

  // line hit test
  logic [LW:0] low_edge, high_edge;
  logic        hit;

  assign low_edge  = {1'b0, line_q} + (tall_q ? (LW+1)'(0) : (LW+1)'(ssel_pkg::SHORT_HEIGHT));
  assign high_edge = {1'b0, line_q} + (LW+1)'(ssel_pkg::Y_OFFSET);
  assign hit = ({1'b0, item_q.idx} < (IW+1)'(ENTRY_COUNT))
             & (low_edge < {1'b0, y_q})
             & (high_edge >= {1'b0, y_q});

  // output register
  logic            out_vld_q, out_none_q, out_last_q;
  ssel_pkg::pick_t out_pick_q;
  logic            out_free, out_load, out_load_none;

  // cell row
  logic [LIST_DEPTH-1:0] vld, keep;
  ssel_pkg::pick_t       pick [LIST_DEPTH];
  ssel_pkg::cell_ctrl_t  ctrl;
  logic                  top_vld;

  assign top_vld = vld[LIST_DEPTH-1];
  assign out_free = ~out_vld_q | m_axis_tready_i;

  always_comb begin
    ctrl.insert = (state_q == S_INSERT) & hit;
    ctrl.shift  = (state_q == S_DRAIN) & (~top_vld | out_free);
  end

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic            l_vld, l_keep;
    ssel_pkg::pick_t l_pick;
    if (i == 0) begin : g_head
      assign l_vld  = 1'b0;
      assign l_keep = 1'b1;
      assign l_pick = item_q;
    end else begin : g_body
      assign l_vld  = vld[i-1];
      assign l_keep = keep[i-1];
      assign l_pick = pick[i-1];
    end
    ssel_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_i       (item_q),
      .left_vld_i  (l_vld),
      .left_pick_i (l_pick),
      .left_keep_i (l_keep),
      .vld_o       (vld[i]),
      .pick_o      (pick[i]),
      .keep_o      (keep[i])
    );
  end

  assign out_load      = (state_q == S_DRAIN) & top_vld & out_free;
  assign out_load_none = (state_q == S_EMPTY) & out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load || out_load_none) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pick_q <= pick[LIST_DEPTH-1];
      out_none_q <= 1'b0;
      // lowest slot when nothing valid is left below the top cell
      out_last_q <= (vld == TopOnly);
    end else if (out_load_none) begin
      out_pick_q <= '0;
      out_none_q <= 1'b1;
      out_last_q <= 1'b1;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, out_pick_q.x, out_pick_q.idx};
  assign m_axis_tuser_o  = out_none_q;
  assign m_axis_tlast_o  = out_last_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_INSERT;
      end
      S_INSERT: begin
        if (!fin_q) begin
          state_d = S_IDLE;
        end else if (vld[0] || hit) begin
          state_d = S_DRAIN;
        end else begin
          state_d = S_EMPTY;
        end
      end
      S_DRAIN: begin
        if (vld == '0) state_d = S_IDLE;
      end
      S_EMPTY: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `SSEL_ASSERT(a_list_prefix, (state_q == S_IDLE) |-> (((vld + 1'b1) & vld) == '0), "list not packed from slot 0")
  `SSEL_ASSERT(a_drain_empties, ((state_q == S_IDLE) && $past(state_q == S_DRAIN)) |-> (vld == '0), "list not empty after drain")
  `SSEL_ASSERT(a_last_clears, ($past(out_load) && out_last_q) |-> (vld == '0), "picks left behind last result")

endmodule
